// File: rtl/assert_macros.svh
// Assertion helpers. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: rtl/spa_pkg.sv
package spa_pkg;

  localparam int INT_BITS  = 16;
  localparam int FRAC_BITS = 8;
  localparam int LEN_W     = INT_BITS + FRAC_BITS;
  localparam int SUM_W     = LEN_W + 2;
  localparam int PERIM_W   = 27;
  localparam int AREA_W    = 42;
  localparam int PI_FRAC   = 30;
  localparam logic [31:0] PI_Q = 32'd3373259426;
  localparam int PR_W      = 32 + LEN_W;
  localparam int RAD_W     = 4 * SUM_W;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int CELLS     = ROOT_W;
  localparam int LATENCY   = CELLS + 6;

  localparam logic [1:0] MODE_TRI  = 2'd0;
  localparam logic [1:0] MODE_RECT = 2'd1;
  localparam logic [1:0] MODE_CIRC = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_NOTRI = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [LEN_W-1:0] side_a;
    logic [LEN_W-1:0] side_b;
    logic [LEN_W-1:0] side_c;
  } spa_in_t;

  typedef struct packed {
    logic [PERIM_W-1:0] perimeter;
    logic [AREA_W-1:0]  surface;
    logic [1:0]         status;
  } spa_out_t;

  typedef struct packed {
    logic              is_tri;
    spa_out_t          res;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } spa_cell_t;

endpackage

// File: rtl/spa_front.sv
module spa_front import spa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  spa_in_t   in_i,
  output logic      vld_o,
  output spa_cell_t cell_o
);

  localparam int HALF = SUM_W;
  localparam int PRH  = PR_W / 2;
  localparam int CW   = PR_W + LEN_W;

  logic [4:0] vld_q;

  spa_in_t in1_q;

  logic [1:0]       mode2_q, st2_q;
  logic [SUM_W-1:0] sum2_q, x2_q, y2_q, z2_q;
  logic [LEN_W-1:0] a2_q, b2_q;
  logic [1:0]       st2_d;

  logic [1:0]         mode3_q, st3_q;
  logic [2*SUM_W-1:0] p1_q, p2_q;
  logic [2*LEN_W-1:0] ab_q;
  logic [PR_W-1:0]    pr_q;
  logic [PERIM_W-1:0] per3_q, per3_d;
  logic [LEN_W-1:0]   a3_q;

  logic [1:0]           mode4_q, st4_q;
  logic [2*HALF-1:0]    pp0_q, pp1_q, pp2_q, pp3_q;
  logic [PRH+LEN_W-1:0] q0_q, q1_q;
  logic [PERIM_W-1:0]   per4_q, per4_d;
  logic [AREA_W-1:0]    area4_q;

  logic [RAD_W-1:0] rad_d;
  logic [CW-1:0]    circ_d;
  logic [AREA_W-1:0] area_d;
  spa_cell_t        cell_q;

  logic [SUM_W-1:0] a_e, b_e, c_e, sum_e, big_e;

  assign a_e   = SUM_W'(in1_q.side_a);
  assign b_e   = SUM_W'(in1_q.side_b);
  assign c_e   = SUM_W'(in1_q.side_c);
  assign sum_e = a_e + b_e + c_e;

  always_comb begin
    big_e = (a_e > b_e) ? a_e : b_e;
    if (c_e > big_e) begin
      big_e = c_e;
    end
    unique case (in1_q.mode)
      MODE_TRI: begin
        if (a_e == '0 || b_e == '0 || c_e == '0) begin
          st2_d = ST_ZERO;
        end else if (big_e >= sum_e - big_e) begin
          st2_d = ST_NOTRI;
        end else begin
          st2_d = ST_OK;
        end
      end
      MODE_RECT: st2_d = (a_e == '0 || b_e == '0) ? ST_ZERO : ST_OK;
      default:   st2_d = (a_e == '0) ? ST_ZERO : ST_OK;
    endcase
  end

  always_comb begin
    unique case (mode2_q)
      MODE_TRI:  per3_d = PERIM_W'(sum2_q);
      MODE_RECT: per3_d = PERIM_W'({(SUM_W-1)'(a2_q) + (SUM_W-1)'(b2_q), 1'b0});
      default:   per3_d = '0;
    endcase
  end

  always_comb begin
    unique case (mode3_q)
      MODE_TRI, MODE_RECT: per4_d = per3_q;
      default:             per4_d = PERIM_W'(pr_q >> (PI_FRAC - 1));
    endcase
  end

  assign rad_d = RAD_W'(pp0_q)
               + (RAD_W'(RAD_W'(pp1_q) + RAD_W'(pp2_q)) << HALF)
               + (RAD_W'(pp3_q) << (2 * HALF));
  assign circ_d = CW'(q0_q) + (CW'(q1_q) << PRH);

  always_comb begin
    unique case (mode4_q)
      MODE_TRI:  area_d = '0;
      MODE_RECT: area_d = area4_q;
      default:   area_d = AREA_W'(circ_d >> (PI_FRAC + FRAC_BITS));
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    in1_q <= in_i;

    mode2_q <= in1_q.mode;
    st2_q   <= st2_d;
    sum2_q  <= sum_e;
    x2_q    <= b_e + c_e - a_e;
    y2_q    <= a_e + c_e - b_e;
    z2_q    <= a_e + b_e - c_e;
    a2_q    <= in1_q.side_a;
    b2_q    <= in1_q.side_b;

    mode3_q <= mode2_q;
    st3_q   <= st2_q;
    p1_q    <= sum2_q * x2_q;
    p2_q    <= y2_q * z2_q;
    ab_q    <= a2_q * b2_q;
    pr_q    <= PI_Q * a2_q;
    per3_q  <= per3_d;
    a3_q    <= a2_q;

    mode4_q <= mode3_q;
    st4_q   <= st3_q;
    pp0_q   <= p1_q[HALF-1:0] * p2_q[HALF-1:0];
    pp1_q   <= p1_q[HALF-1:0] * p2_q[2*HALF-1:HALF];
    pp2_q   <= p1_q[2*HALF-1:HALF] * p2_q[HALF-1:0];
    pp3_q   <= p1_q[2*HALF-1:HALF] * p2_q[2*HALF-1:HALF];
    q0_q    <= pr_q[PRH-1:0] * a3_q;
    q1_q    <= pr_q[PR_W-1:PRH] * a3_q;
    per4_q  <= per4_d;
    area4_q <= AREA_W'(ab_q >> FRAC_BITS);

    cell_q.is_tri        <= (st4_q == ST_OK) && (mode4_q == MODE_TRI);
    cell_q.res.status    <= st4_q;
    cell_q.res.perimeter <= (st4_q == ST_OK) ? per4_q : '0;
    cell_q.res.surface   <= (st4_q == ST_OK) ? area_d : '0;
    cell_q.rad           <= rad_d;
    cell_q.root          <= '0;
    cell_q.rem           <= '0;
  end

  assign vld_o  = vld_q[4];
  assign cell_o = cell_q;

endmodule

// File: rtl/spa_sqrt_cell.sv
module spa_sqrt_cell import spa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  spa_cell_t cell_i,
  output logic      vld_o,
  output spa_cell_t cell_o
);

  logic [REM_W+1:0] cur, trial;
  logic             ge;
  logic             vld_q;
  spa_cell_t        cell_q;

  // one root bit per cell, two radicand bits consumed
  assign cur   = {cell_i.rem, cell_i.rad[RAD_W-1 -: 2]};
  assign trial = (REM_W+2)'({cell_i.root, 2'b01});
  assign ge    = cur >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q.is_tri <= cell_i.is_tri;
    cell_q.res    <= cell_i.res;
    cell_q.rad    <= cell_i.rad << 2;
    cell_q.root   <= {cell_i.root[ROOT_W-2:0], ge};
    cell_q.rem    <= ge ? REM_W'(cur - trial) : REM_W'(cur);
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

// File: rtl/shape_perimeter_area_core.sv
// Perimeter and area of a triangle, rectangle or circle, fully pipelined.
// Pipeline of 58 register stages: five operand/multiply stages, 52 square-root
// cells, one output register. Throughput: one beat per cycle, busy is never high.
// The receiver cannot stall the pipe; results are never held back.
// Reset clears the valid bits of every stage; no result leaves after reset.
`include "assert_macros.svh"

module shape_perimeter_area_core import spa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  spa_in_t  in_i,
  output logic     strobe_o,
  output spa_out_t res_o
);

  logic      vld_c  [CELLS+1];
  spa_cell_t cell_c [CELLS+1];
  logic      strobe_q;
  spa_out_t  res_q;
  spa_out_t  res_d;

  assign busy = 1'b0;

  spa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start),
    .in_i   (in_i),
    .vld_o  (vld_c[0]),
    .cell_o (cell_c[0])
  );

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    spa_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld_c[g]),
      .cell_i (cell_c[g]),
      .vld_o  (vld_c[g+1]),
      .cell_o (cell_c[g+1])
    );
  end

  always_comb begin
    res_d = cell_c[CELLS].res;
    if (cell_c[CELLS].is_tri) begin
      res_d.surface = AREA_W'(cell_c[CELLS].root >> (FRAC_BITS + 2));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= vld_c[CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, strobe_o && res_o.status != ST_OK, res_o.perimeter == '0 && res_o.surface == '0)
  `ASSERT_IMPL(a_ok_perim, clk_i, rst_ni, strobe_o && res_o.status == ST_OK, res_o.perimeter != '0)
  `ASSERT_IMPL(a_latency, clk_i, rst_ni, strobe_o, $past(start, LATENCY))
  `ASSERT_NEVER(a_no_busy, clk_i, rst_ni, busy)

endmodule

// File: tb/shape_perimeter_area_core_test.sv
module shape_perimeter_area_core_test;
  import spa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 2000;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [1:0] MODE_RSVD = 2'd3;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  spa_in_t  in_i;
  logic     strobe_o;
  spa_out_t res_o;

  spa_out_t expected_q[$];
  int       errors;
  int       sent;
  int       checked;
  int       idle_pct;
  int       stall_cycles = 0;
  int       n_tri, n_rect, n_circ, n_zero, n_notri;

  shape_perimeter_area_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .strobe_o(strobe_o),
    .res_o   (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root_floor(logic [RAD_W-1:0] v);
    logic [63:0]      r;
    logic [63:0]      c;
    logic [RAD_W-1:0] sq;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = RAD_W'(c) * RAD_W'(c);
      if (sq <= v) r = c;
    end
    return r;
  endfunction

  function automatic spa_out_t shape_result(spa_in_t it);
    spa_out_t         o;
    logic [SUM_W-1:0] a, b, c, s, big;
    logic [RAD_W-1:0] prod;
    logic [127:0]     w;
    o = '0;
    a = SUM_W'(it.side_a);
    b = SUM_W'(it.side_b);
    c = SUM_W'(it.side_c);
    if (it.mode == MODE_TRI) begin
      s   = a + b + c;
      big = (a > b) ? a : b;
      if (c > big) big = c;
      if (a == 0 || b == 0 || c == 0) o.status = ST_ZERO;
      else if (big >= s - big) o.status = ST_NOTRI;
      else begin
        prod = RAD_W'(s) * RAD_W'(b + c - a) * RAD_W'(a + c - b) * RAD_W'(a + b - c);
        o.perimeter = PERIM_W'(s);
        o.surface   = AREA_W'(root_floor(prod) >> (FRAC_BITS + 2));
      end
    end else if (it.mode == MODE_RECT) begin
      if (a == 0 || b == 0) o.status = ST_ZERO;
      else begin
        o.perimeter = PERIM_W'((a + b) << 1);
        w = 128'(a) * 128'(b);
        o.surface = AREA_W'(w >> FRAC_BITS);
      end
    end else begin
      if (a == 0) o.status = ST_ZERO;
      else begin
        w = 128'(PI_Q) * 128'(a);
        o.perimeter = PERIM_W'((w * 2) >> PI_FRAC);
        o.surface   = AREA_W'((w * 128'(a)) >> (PI_FRAC + FRAC_BITS));
      end
    end
    return o;
  endfunction

  task automatic send_shape(logic [1:0] mode, logic [LEN_W-1:0] a, logic [LEN_W-1:0] b,
                            logic [LEN_W-1:0] c);
    spa_in_t  it;
    spa_out_t e;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    it.mode = mode; it.side_a = a; it.side_b = b; it.side_c = c;
    start <= 1'b1;
    in_i  <= it;
    do @(posedge clk_i); while (busy);
    e = shape_result(it);
    expected_q.push_back(e);
    sent++;
    case (e.status)
      ST_ZERO:  n_zero++;
      ST_NOTRI: n_notri++;
      default:  ;
    endcase
    if (mode == MODE_TRI) n_tri++;
    else if (mode == MODE_RECT) n_rect++;
    else n_circ++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(3))
      0:       return LEN_W'($urandom_range(1, 255));
      1:       return LEN_W'($urandom_range(1, 65535));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_shape(MODE_TRI, 24'h000100, 24'h000100, 24'h000100);
    send_shape(MODE_TRI, LEN_MAX, LEN_MAX, LEN_MAX);
    send_shape(MODE_TRI, 24'h000300, 24'h000400, 24'h000500);
    send_shape(MODE_TRI, 24'h000001, 24'h000001, 24'h000001);
    send_shape(MODE_TRI, '0, 24'h000100, 24'h000100);
    send_shape(MODE_TRI, 24'h000100, '0, 24'h000100);
    send_shape(MODE_TRI, 24'h000100, 24'h000100, '0);
    send_shape(MODE_TRI, 24'h000100, 24'h000200, 24'h000100);
    send_shape(MODE_TRI, 24'h000100, 24'h000100, 24'h000500);
    send_shape(MODE_TRI, LEN_MAX, 24'h000001, 24'h000001);
    send_shape(MODE_TRI, LEN_MAX, LEN_MAX, 24'h000001);
    send_shape(MODE_RECT, LEN_MAX, LEN_MAX, 24'h123456);
    send_shape(MODE_RECT, 24'h000001, 24'h000001, '0);
    send_shape(MODE_RECT, '0, 24'h000100, LEN_MAX);
    send_shape(MODE_RECT, 24'h000100, '0, LEN_MAX);
    send_shape(MODE_CIRC, LEN_MAX, LEN_MAX, LEN_MAX);
    send_shape(MODE_CIRC, 24'h000001, '0, '0);
    send_shape(MODE_CIRC, 24'h000100, 24'h000200, 24'h000300);
    send_shape(MODE_CIRC, '0, 24'h000100, 24'h000100);
    send_shape(MODE_RSVD, 24'h000100, '0, '0);
    send_shape(MODE_RSVD, LEN_MAX, LEN_MAX, LEN_MAX);
    send_shape(MODE_RSVD, '0, LEN_MAX, LEN_MAX);
  endtask

  task automatic test_random(int count);
    logic [LEN_W-1:0] a, b, c;
    int               pick;
    for (int i = 0; i < count; i++) begin
      a = rand_len(); b = rand_len(); c = rand_len();
      pick = $urandom_range(99);
      if (pick < 40) begin
        // mostly valid triangles: c strictly inside |a-b| .. a+b
        a = LEN_W'($urandom_range(2, 24'hFFFFFF));
        b = LEN_W'($urandom_range(2, 24'hFFFFFF));
        if (a > b) c = LEN_W'($urandom_range(a - b + 1, (a + b - 1 > LEN_MAX) ? LEN_MAX
                                                                  : a + b - 1));
        else c = LEN_W'($urandom_range(b - a + 1, (a + b - 1 > LEN_MAX) ? LEN_MAX
                                                             : a + b - 1));
        send_shape(MODE_TRI, a, b, c);
      end else if (pick < 50) begin
        if ($urandom_range(1)) a = '0;
        send_shape(MODE_TRI, a, b, c);
      end else if (pick < 72) begin
        if ($urandom_range(9) == 0) b = '0;
        send_shape(MODE_RECT, a, b, c);
      end else if (pick < 94) begin
        if ($urandom_range(19) == 0) a = '0;
        send_shape(MODE_CIRC, a, b, c);
      end else begin
        send_shape(MODE_RSVD, a, b, c);
      end
    end
  endtask

  task automatic test_pause();
    wait_drained();
    send_shape(MODE_TRI, 24'h000500, 24'h000500, 24'h000600);
  endtask

  always @(posedge clk_i) begin
    spa_out_t e;
    if (rst_ni && strobe_o) begin
      checked++;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: %p", $time, res_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res_o.perimeter !== e.perimeter) begin
          $display("%0t: perimeter expected %0d got %0d", $time, e.perimeter,
                   res_o.perimeter);
          errors++;
        end
        if (res_o.surface !== e.surface) begin
          $display("%0t: surface expected %0d got %0d", $time, e.surface,
                   res_o.surface);
          errors++;
        end
        if (res_o.status !== e.status) begin
          $display("%0t: status expected %0d got %0d", $time, e.status, res_o.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCH_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
      $display("shape_perimeter_area_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0; sent = 0; checked = 0;
    n_tri = 0; n_rect = 0; n_circ = 0; n_zero = 0; n_notri = 0;
    idle_pct = 30;
    rst_ni = 1'b0;
    start  = 1'b0;
    in_i   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    test_pause();
    idle_pct = 0;
    test_random(250);
    idle_pct = 30;
    test_random(280);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("beats %0d, checked %0d: %0d triangle, %0d rectangle, %0d circle",
             sent, checked, n_tri, n_rect, n_circ);
    $display("error cases: %0d zero length, %0d not a triangle", n_zero, n_notri);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("shape_perimeter_area_core_test: PASS");
    end else begin
      $display("shape_perimeter_area_core_test: FAIL");
    end
    $finish;
  end

endmodule
